[rtl/lss_pkg.sv]
// Shared types and codes for the LIFO stack with search.
// Depends on nothing; every other file imports it.
package lss_pkg;

	// Fixed port widths.
	localparam int unsigned REQ_W    = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned INDEX_W  = 4;
	localparam int unsigned COUNT_W  = 5;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	// Control broadcast to every storage cell.
	typedef struct packed {
		logic load;   // capture compare result into the match flag
		logic shift;  // take the match flag of the cell above
	} lss_cell_ctrl_t;

endpackage

[rtl/lss_cell.sv]
// One storage cell of the stack: a word register and a match flag that
// moves one cell toward the bottom per search step. Depends on lss_pkg.
module lss_cell #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lss_pkg::lss_cell_ctrl_t ctrl,
	input  logic                    wr_en,
	input  logic [DATA_WIDTH-1:0]   din,
	input  logic [DATA_WIDTH-1:0]   key,
	input  logic                    in_range,
	input  logic                    flag_in,
	output logic                    flag_out
);
	import lss_pkg::*;

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  flag_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.load) begin
			flag_q <= in_range && (entry_q == key);
		end else if (ctrl.shift) begin
			flag_q <= flag_in;
		end
	end

	assign flag_out = flag_q;

endmodule

[rtl/lifo_stack_with_search.sv]
// Top level of the fixed-depth LIFO stack with key search.
// Depends on lss_pkg and lss_cell.
//
// Send a request by raising start with req_type and value while busy is low;
// that beat is taken at the clock edge. Push, pop and the unused code 3 never
// raise busy: the result beat shows on the next cycle and the block takes a
// new request in that same cycle. A search holds busy high while match flags,
// loaded by a parallel compare in every cell, shift one cell per cycle toward
// the bottom cell. Busy falls once the lowest hit, at position k, reaches the
// bottom cell, or on a miss once the walk has passed every held entry. The
// result beat shows in the cycle in which busy falls, and a new request can be
// taken in that cycle. Each result beat is on the output ports for exactly one
// cycle, marked by done; there is no backpressure, so capture it when done is
// high. A pop on an empty stack and a push on a full one report an error
// status and leave the stack as is.
module lifo_stack_with_search #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [lss_pkg::REQ_W-1:0]          req_type,
	input  logic signed [lss_pkg::VALUE_W-1:0] value,
	output logic                               done,
	output logic [lss_pkg::STATUS_W-1:0]       status,
	output logic                               found,
	output logic [lss_pkg::INDEX_W-1:0]        match_index,
	output logic [lss_pkg::COUNT_W-1:0]        element_count,
	output logic                               is_empty
);
	import lss_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_SEARCH = 1'b1;

	logic                  state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         pos_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  found_q;
	logic [INDEX_W-1:0]    index_q;
	logic [COUNT_W-1:0]    count_out_q;
	logic                  empty_q;

	logic                  accept;
	logic [DATA_WIDTH-1:0] word;
	logic                  scan_end;
	lss_cell_ctrl_t        cell_ctrl;
	logic [DEPTH-1:0]      wr_en;
	logic [DEPTH-1:0]      flag;
	logic [DEPTH:0]        flag_chain;

	assign busy   = (state_q == S_SEARCH);
	assign accept = start && !busy;
	// Keep the low DATA_WIDTH bits of the beat; widen by sign.
	assign word   = DATA_WIDTH'(value);

	// Scan is over once the walk has passed every held entry.
	assign scan_end = (pos_q == count_q);

	assign cell_ctrl.load  = accept && (req_type == REQ_SEARCH);
	assign cell_ctrl.shift = busy && !scan_end && !flag[0];

	// Top cell takes a cleared flag when the chain shifts down.
	assign flag_chain[DEPTH] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		// Push writes the cell just above the current top.
		assign wr_en[i] = accept && (req_type == REQ_PUSH) && (count_q == CW'(i));

		lss_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.wr_en    (wr_en[i]),
			.din      (word),
			.key      (key_q),
			.in_range (count_q > CW'(i)),
			.flag_in  (flag_chain[i+1]),
			.flag_out (flag[i])
		);

		assign flag_chain[i] = flag[i];
	end

	// The compare in each cell uses the key in the same cycle as start, so
	// route the incoming word directly while loading.
	always_comb begin
		key_q = word;
	end

	// Control: stack count, search walk and done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy) begin
				if (scan_end || flag[0]) begin
					// Hit or miss settled: emit the beat and drop busy.
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end else begin
					// Advance the walk by one cell.
					pos_q <= pos_q + CW'(1);
				end
			end else if (accept) begin
				unique case (req_type)
					REQ_PUSH: begin
						if (count_q != FULL_COUNT) begin
							count_q <= count_q + CW'(1);
						end
						done_q <= 1'b1;
					end
					REQ_POP: begin
						if (count_q != '0) begin
							count_q <= count_q - CW'(1);
						end
						done_q <= 1'b1;
					end
					REQ_SEARCH: begin
						state_q <= S_SEARCH;
						pos_q   <= '0;
					end
					REQ_NOP: begin
						done_q <= 1'b1;
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	// Result payload; only meaningful while done is high.
	always_ff @(posedge clk) begin
		if (busy) begin
			status_q    <= STAT_OK;
			found_q     <= !scan_end && flag[0];
			index_q     <= (!scan_end && flag[0]) ? INDEX_W'(pos_q) : '0;
			count_out_q <= COUNT_W'(count_q);
			empty_q     <= (count_q == '0);
		end else if (accept) begin
			found_q <= 1'b0;
			index_q <= '0;
			unique case (req_type)
				REQ_PUSH: begin
					if (count_q == FULL_COUNT) begin
						status_q    <= STAT_FULL;
						count_out_q <= COUNT_W'(count_q);
						empty_q     <= (count_q == '0);
					end else begin
						status_q    <= STAT_OK;
						count_out_q <= COUNT_W'(count_q + CW'(1));
						empty_q     <= 1'b0;
					end
				end
				REQ_POP: begin
					if (count_q == '0) begin
						status_q    <= STAT_EMPTY;
						count_out_q <= '0;
						empty_q     <= 1'b1;
					end else begin
						status_q    <= STAT_OK;
						count_out_q <= COUNT_W'(count_q - CW'(1));
						empty_q     <= (count_q == CW'(1));
					end
				end
				REQ_SEARCH: begin
					status_q    <= STAT_OK;
					count_out_q <= COUNT_W'(count_q);
					empty_q     <= (count_q == '0);
				end
				REQ_NOP: begin
					status_q    <= STAT_OK;
					count_out_q <= COUNT_W'(count_q);
					empty_q     <= (count_q == '0);
				end
				default: begin
					status_q    <= STAT_OK;
					count_out_q <= COUNT_W'(count_q);
					empty_q     <= (count_q == '0);
				end
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign found         = found_q;
	assign match_index   = index_q;
	assign element_count = count_out_q;
	assign is_empty      = empty_q;

endmodule

[rtl/lss_checker.sv]
// Port-level checks for the LIFO stack with search, bound to the top level.
// Depends on lss_pkg and lifo_stack_with_search.
module lss_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic [lss_pkg::REQ_W-1:0]          req_type,
	input logic                               done,
	input logic [lss_pkg::STATUS_W-1:0]       status,
	input logic                               found,
	input logic [lss_pkg::INDEX_W-1:0]        match_index,
	input logic [lss_pkg::COUNT_W-1:0]        element_count,
	input logic                               is_empty
);
	import lss_pkg::*;

	// A non-search request yields its beat on the very next cycle.
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type != REQ_SEARCH) |=> done)
		else $error("push/pop/no-op beat missing on next cycle");

	// No beat while a search is still walking.
	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result beat during search");

	// Empty flag agrees with the reported count.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (element_count == '0)))
		else $error("is_empty disagrees with element_count");

	// A hit lies below the count and never comes with an error status.
	a_hit_sane: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> (status == STAT_OK) && (COUNT_W'(match_index) < element_count))
		else $error("search hit outside held entries");

	// An error beat reports no hit and no index.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STAT_OK) |-> !found && (match_index == '0))
		else $error("error beat carries search result");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (.*);
